/* rtl/sacd_pkg.sv */
// ----------------------------------------------------------------------------
// sacd_pkg
// Types and constants shared by the serial attribute cell decoder.
// ----------------------------------------------------------------------------
package sacd_pkg;

    // Row attribute state carried from one word to the next.
    typedef struct packed {
        logic [2:0] fg_colour;
        logic [2:0] bg_colour;
        logic       flash_on;
        logic       conceal_on;
        logic       double_on;
        logic       hold_on;
        logic       mosaic_on;
        logic       separated_on;
        logic [7:0] held_mosaic;
        logic       escape_pending;
    } attr_state_t;

    // One display cell.
    typedef struct packed {
        logic [7:0] glyph;
        logic [2:0] fore_colour;
        logic [2:0] back_colour;
        logic       flashing;
        logic       concealed;
        logic       double_height;
        logic       separated;
        logic       control_cell;
    } cell_t;

    localparam logic [2:0] COLOUR_BLACK = 3'd0;
    localparam logic [2:0] COLOUR_WHITE = 3'd7;

    localparam attr_state_t ROW_RESET_STATE = '{
        fg_colour:      COLOUR_WHITE,
        bg_colour:      COLOUR_BLACK,
        flash_on:       1'b0,
        conceal_on:     1'b0,
        double_on:      1'b0,
        hold_on:        1'b0,
        mosaic_on:      1'b0,
        separated_on:   1'b0,
        held_mosaic:    8'h00,
        escape_pending: 1'b0
    };

    // Operation codes of an input word.
    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_ROW_START = 1'b1;

    // Byte codes.
    localparam logic [7:0] CODE_ESC       = 8'h1B;
    localparam logic [7:0] CODE_SPACE     = 8'h20;
    localparam logic [7:0] CODE_HASH      = 8'h23;
    localparam logic [7:0] CODE_UNDERLINE = 8'h5F;
    localparam logic [7:0] CODE_BACKTICK  = 8'h60;
    localparam logic [7:0] CODE_DEL       = 8'h7F;
    localparam logic [7:0] C0_LIMIT       = 8'h20;
    localparam logic [7:0] C1_FIRST       = 8'h80;
    localparam logic [7:0] C1_LAST        = 8'h9F;
    localparam logic [7:0] UPPER_FIRST    = 8'hA0;
    localparam logic [7:0] ESC_CTL_FIRST  = 8'h40;
    localparam logic [7:0] ESC_CTL_LAST   = 8'h5F;
    localparam logic [7:0] MOSAIC_BIT     = 8'h80;
    localparam logic [7:0] MOSAIC_MIN     = 8'hA0;

    // Control values (0x40-0x5F).
    localparam logic [7:0] CTL_ALPHA_FIRST  = 8'h41;
    localparam logic [7:0] CTL_ALPHA_LAST   = 8'h47;
    localparam logic [7:0] CTL_FLASH        = 8'h48;
    localparam logic [7:0] CTL_STEADY       = 8'h49;
    localparam logic [7:0] CTL_NORMAL       = 8'h4C;
    localparam logic [7:0] CTL_DOUBLE       = 8'h4D;
    localparam logic [7:0] CTL_MOSAIC_FIRST = 8'h51;
    localparam logic [7:0] CTL_MOSAIC_LAST  = 8'h57;
    localparam logic [7:0] CTL_CONCEAL      = 8'h58;
    localparam logic [7:0] CTL_CONTIGUOUS   = 8'h59;
    localparam logic [7:0] CTL_SEPARATED    = 8'h5A;
    localparam logic [7:0] CTL_BLACK_BACK   = 8'h5C;
    localparam logic [7:0] CTL_NEW_BACK     = 8'h5D;
    localparam logic [7:0] CTL_HOLD         = 8'h5E;
    localparam logic [7:0] CTL_RELEASE      = 8'h5F;

endpackage

/* rtl/sacd_if.sv */
// ----------------------------------------------------------------------------
// sacd_item_if / sacd_cell_if
// Valid/ready channels for received bytes and decoded display cells.
// ----------------------------------------------------------------------------
interface sacd_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] code;

    modport source (output valid, output operation, output code, input ready);
    modport sink   (input valid, input operation, input code, output ready);
endinterface

interface sacd_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph;
    logic [2:0] fore_colour;
    logic [2:0] back_colour;
    logic       flashing;
    logic       concealed;
    logic       double_height;
    logic       separated;
    logic       control_cell;

    modport source (
        output valid, output glyph, output fore_colour, output back_colour,
        output flashing, output concealed, output double_height,
        output separated, output control_cell, input ready
    );
    modport sink (
        input valid, input glyph, input fore_colour, input back_colour,
        input flashing, input concealed, input double_height,
        input separated, input control_cell, output ready
    );
endinterface

/* rtl/sacd_cell.sv */
// ----------------------------------------------------------------------------
// sacd_cell
// Decodes one word against the current attribute state: next state and the
// display cell, if the word makes one.
// ----------------------------------------------------------------------------
module sacd_cell (
    input  sacd_pkg::attr_state_t state,
    input  logic                  micro_mode,
    input  logic                  operation,
    input  logic [7:0]            code,
    output sacd_pkg::attr_state_t state_next,
    output logic                  cell_valid,
    output sacd_pkg::cell_t       cell_data
);
    import sacd_pkg::*;

    // Set-at controls take effect before the cell is formed.
    function automatic attr_state_t apply_before(attr_state_t s, logic [7:0] c);
        attr_state_t r;
        r = s;
        case (c)
            CTL_STEADY:     r.flash_on = 1'b0;
            CTL_NORMAL:
            begin
                r.hold_on     = 1'b0;
                r.held_mosaic = 8'h00;
                r.double_on   = 1'b0;
            end
            CTL_CONCEAL:    r.conceal_on = 1'b1;
            CTL_CONTIGUOUS:
            begin
                if (!s.hold_on)
                begin
                    r.held_mosaic = 8'h00;
                end
                r.separated_on = 1'b0;
            end
            CTL_SEPARATED:
            begin
                if (!s.hold_on)
                begin
                    r.held_mosaic = 8'h00;
                end
                r.separated_on = 1'b1;
            end
            CTL_BLACK_BACK: r.bg_colour = COLOUR_BLACK;
            CTL_NEW_BACK:   r.bg_colour = s.fg_colour;
            CTL_HOLD:       r.hold_on = 1'b1;
            default:        r = s;
        endcase
        return r;
    endfunction

    // Set-after controls take effect once the cell has been formed.
    function automatic attr_state_t apply_after(attr_state_t s, logic [7:0] c);
        attr_state_t r;
        logic        alpha;
        logic        mosaic;
        r      = s;
        alpha  = (c >= CTL_ALPHA_FIRST) && (c <= CTL_ALPHA_LAST);
        mosaic = (c >= CTL_MOSAIC_FIRST) && (c <= CTL_MOSAIC_LAST);
        if (alpha || mosaic)
        begin
            r.conceal_on = 1'b0;
            r.fg_colour  = c[2:0];
            if (alpha)
            begin
                r.hold_on   = 1'b0;
                r.mosaic_on = 1'b0;
            end
            else
            begin
                r.mosaic_on = 1'b1;
            end
            if (!r.hold_on)
            begin
                r.held_mosaic = 8'h00;
            end
        end
        else if (c == CTL_FLASH)
        begin
            r.flash_on = 1'b1;
        end
        else if (c == CTL_DOUBLE)
        begin
            r.hold_on     = 1'b0;
            r.held_mosaic = 8'h00;
            r.double_on   = 1'b1;
        end
        else if (c == CTL_RELEASE)
        begin
            r.held_mosaic = 8'h00;
            r.hold_on     = 1'b0;
        end
        return r;
    endfunction

    attr_state_t mid;
    logic        is_control;
    logic [7:0]  ctl_value;
    logic [7:0]  ch;

    always_comb
    begin
        state_next = state;
        cell_valid = 1'b0;
        is_control = 1'b0;
        ctl_value  = {2'b01, code[5:0]};
        ch         = code;
        mid        = state;

        cell_data.glyph         = code;
        cell_data.fore_colour   = state.fg_colour;
        cell_data.back_colour   = state.bg_colour;
        cell_data.flashing      = state.flash_on;
        cell_data.concealed     = state.conceal_on;
        cell_data.double_height = state.double_on;
        cell_data.separated     = state.separated_on;
        cell_data.control_cell  = 1'b0;

        if (operation == OP_ROW_START)
        begin
            state_next = ROW_RESET_STATE;
        end
        else if (state.escape_pending)
        begin
            state_next.escape_pending = 1'b0;
            if ((code >= ESC_CTL_FIRST) && (code <= ESC_CTL_LAST))
            begin
                is_control = 1'b1;
                ctl_value  = code;
            end
        end
        else if ((code >= C1_FIRST) && (code <= C1_LAST))
        begin
            is_control = 1'b1;
        end
        else if (code < C0_LIMIT)
        begin
            if ((code == CODE_ESC) && !micro_mode)
            begin
                state_next.escape_pending = 1'b1;
            end
        end
        else if ((code == CODE_DEL) && micro_mode)
        begin
            cell_valid = 1'b0;
        end
        else if (code >= UPPER_FIRST)
        begin
            cell_valid = 1'b1;
        end
        else
        begin
            if (micro_mode)
            begin
                if (code == CODE_HASH)
                begin
                    ch = CODE_UNDERLINE;
                end
                else if (code == CODE_UNDERLINE)
                begin
                    ch = CODE_BACKTICK;
                end
                else if (code == CODE_BACKTICK)
                begin
                    ch = CODE_HASH;
                end
            end
            // Bit 5 of the byte marks the two mosaic columns.
            if (state.mosaic_on)
            begin
                if (code[5])
                begin
                    ch = ch | MOSAIC_BIT;
                end
                if (ch >= MOSAIC_MIN)
                begin
                    state_next.held_mosaic = state.separated_on ? {1'b0, ch[6:0]} : ch;
                end
            end
            cell_data.glyph = ch;
            cell_valid = 1'b1;
        end

        if (is_control)
        begin
            mid        = apply_before(state, ctl_value);
            cell_valid = 1'b1;
            cell_data.fore_colour   = mid.fg_colour;
            cell_data.back_colour   = mid.bg_colour;
            cell_data.flashing      = mid.flash_on;
            cell_data.concealed     = mid.conceal_on;
            cell_data.double_height = mid.double_on;
            cell_data.control_cell  = 1'b1;
            // A stored mosaic with bit 7 clear was captured in separated mode.
            if (mid.hold_on && (mid.held_mosaic != 8'h00))
            begin
                cell_data.glyph     = mid.held_mosaic | MOSAIC_BIT;
                cell_data.separated = ~mid.held_mosaic[7];
            end
            else
            begin
                cell_data.glyph     = CODE_SPACE;
                cell_data.separated = mid.separated_on;
            end
            state_next = apply_after(mid, ctl_value);
            state_next.escape_pending = 1'b0;
        end
    end

endmodule

/* rtl/serial_attribute_cell_decoder.sv */
// ----------------------------------------------------------------------------
// serial_attribute_cell_decoder
// Turns received bytes into display cells with their serial attributes.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held first in the input register and then, once
// decoded, its cell in the result register, which drives the result channel.
// Throughput: one word per cycle while the result side is ready; the state
// update and the cell are formed in the same cycle.
// Reset: rst_n clears both channel stages and returns the attributes to white
// on black with all modes off; micro_mode resets to 0.
module serial_attribute_cell_decoder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    sacd_item_if.sink    item,
    sacd_cell_if.source  result
);
    import sacd_pkg::*;

    logic        micro_mode_reg;
    attr_state_t state_reg;
    attr_state_t state_next;

    logic        in_valid_reg;
    logic        in_operation_reg;
    logic [7:0]  in_code_reg;

    logic        out_valid_reg;
    cell_t       out_cell_reg;

    logic        cell_valid;
    cell_t       cell_data;
    logic        advance;

    // The decode stage moves on whenever the result register is free or
    // being emptied, whether or not the word makes a cell.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    sacd_cell u_cell (
        .state      (state_reg),
        .micro_mode (micro_mode_reg),
        .operation  (in_operation_reg),
        .code       (in_code_reg),
        .state_next (state_next),
        .cell_valid (cell_valid),
        .cell_data  (cell_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            micro_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            micro_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_operation_reg <= item.operation;
            in_code_reg      <= item.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ROW_RESET_STATE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cell_valid;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cell_valid)
        begin
            out_cell_reg <= cell_data;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.glyph         = out_cell_reg.glyph;
    assign result.fore_colour   = out_cell_reg.fore_colour;
    assign result.back_colour   = out_cell_reg.back_colour;
    assign result.flashing      = out_cell_reg.flashing;
    assign result.concealed     = out_cell_reg.concealed;
    assign result.double_height = out_cell_reg.double_height;
    assign result.separated     = out_cell_reg.separated;
    assign result.control_cell  = out_cell_reg.control_cell;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial attribute cell decoder. Bytes and row
// starts are sent over the item channel with random gaps. An attribute
// predictor in the bench works out each display cell. Every cell taken from
// the result channel is compared field by field against the oldest
// prediction, while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sacd_pkg::*;

    // A C1 byte carries its control value plus this offset.
    localparam logic [7:0] C1_OFFSET = C1_FIRST - ESC_CTL_FIRST;

    // Row attributes as the predictor tracks them.
    typedef struct {
        logic [2:0] fore;
        logic [2:0] back;
        logic       flash;
        logic       conceal;
        logic       tall;
        logic       hold;
        logic       mosaic;
        logic       sep;
        logic [7:0] held;
        logic       esc_seen;
    } row_attr_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    sacd_item_if item_ch ();
    sacd_cell_if cell_ch ();

    row_attr_t attr;
    logic      micro_model;
    cell_t     expected_cells[$];
    int        fail_count;
    int        cells_predicted;
    int        send_max_gap;
    int        recv_max_gap;
    int        hold_cycles;

    serial_attribute_cell_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (cell_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Attribute predictor
    // ------------------------------------------------------------------
    function automatic void clear_row();
        attr.fore     = COLOUR_WHITE;
        attr.back     = COLOUR_BLACK;
        attr.flash    = 1'b0;
        attr.conceal  = 1'b0;
        attr.tall     = 1'b0;
        attr.hold     = 1'b0;
        attr.mosaic   = 1'b0;
        attr.sep      = 1'b0;
        attr.held     = 8'h00;
        attr.esc_seen = 1'b0;
    endfunction

    function automatic cell_t make_cell(input logic [7:0] glyph, input logic sep,
                                        input logic ctl);
        cell_t c;
        c.glyph         = glyph;
        c.fore_colour   = attr.fore;
        c.back_colour   = attr.back;
        c.flashing      = attr.flash;
        c.concealed     = attr.conceal;
        c.double_height = attr.tall;
        c.separated     = sep;
        c.control_cell  = ctl;
        return c;
    endfunction

    function automatic void set_fore(input logic alpha, input logic [2:0] colour);
        attr.conceal = 1'b0;
        attr.fore    = colour;
        if (alpha)
        begin
            attr.hold   = 1'b0;
            attr.mosaic = 1'b0;
        end
        else
        begin
            attr.mosaic = 1'b1;
        end
        if (!attr.hold)
            attr.held = 8'h00;
    endfunction

    function automatic cell_t control_cell(input logic [7:0] ctl);
        cell_t c;
        // Set-at controls take effect before the cell is formed.
        case (ctl)
            CTL_STEADY:     attr.flash = 1'b0;
            CTL_NORMAL:
            begin
                attr.hold = 1'b0;
                attr.held = 8'h00;
                attr.tall = 1'b0;
            end
            CTL_CONCEAL:    attr.conceal = 1'b1;
            CTL_CONTIGUOUS:
            begin
                if (!attr.hold)
                    attr.held = 8'h00;
                attr.sep = 1'b0;
            end
            CTL_SEPARATED:
            begin
                if (!attr.hold)
                    attr.held = 8'h00;
                attr.sep = 1'b1;
            end
            CTL_BLACK_BACK: attr.back = COLOUR_BLACK;
            CTL_NEW_BACK:   attr.back = attr.fore;
            CTL_HOLD:       attr.hold = 1'b1;
            default:        ;
        endcase

        // A held glyph stored with bit 7 clear was captured in separated mode.
        if (attr.hold && attr.held != 8'h00)
            c = make_cell(attr.held | MOSAIC_BIT, !attr.held[7], 1'b1);
        else
            c = make_cell(CODE_SPACE, attr.sep, 1'b1);

        // Set-after controls change the state once the cell is out.
        if (ctl >= CTL_ALPHA_FIRST && ctl <= CTL_ALPHA_LAST)
            set_fore(1'b1, ctl[2:0]);
        else if (ctl >= CTL_MOSAIC_FIRST && ctl <= CTL_MOSAIC_LAST)
            set_fore(1'b0, ctl[2:0]);
        else if (ctl == CTL_FLASH)
            attr.flash = 1'b1;
        else if (ctl == CTL_DOUBLE)
        begin
            attr.hold = 1'b0;
            attr.held = 8'h00;
            attr.tall = 1'b1;
        end
        else if (ctl == CTL_RELEASE)
        begin
            attr.held = 8'h00;
            attr.hold = 1'b0;
        end
        return c;
    endfunction

    // Returns 1 when the word produces a cell, which is then placed in pred.
    function automatic logic decode_word(input logic op, input logic [7:0] b,
                                         output cell_t pred);
        logic [7:0] ch;
        pred = '0;
        if (op == OP_ROW_START)
        begin
            clear_row();
            return 1'b0;
        end
        if (attr.esc_seen)
        begin
            attr.esc_seen = 1'b0;
            if (b >= ESC_CTL_FIRST && b <= ESC_CTL_LAST)
            begin
                pred = control_cell(b);
                return 1'b1;
            end
            return 1'b0;
        end
        if (b >= C1_FIRST && b <= C1_LAST)
        begin
            pred = control_cell(b - C1_OFFSET);
            return 1'b1;
        end
        if (b < C0_LIMIT)
        begin
            if (b == CODE_ESC && !micro_model)
                attr.esc_seen = 1'b1;
            return 1'b0;
        end
        if (b == CODE_DEL && micro_model)
            return 1'b0;
        if (b >= UPPER_FIRST)
        begin
            pred = make_cell(b, attr.sep, 1'b0);
            return 1'b1;
        end
        ch = b;
        if (micro_model)
        begin
            case (b)
                CODE_HASH:      ch = CODE_UNDERLINE;
                CODE_UNDERLINE: ch = CODE_BACKTICK;
                CODE_BACKTICK:  ch = CODE_HASH;
                default:        ;
            endcase
        end
        if (attr.mosaic)
        begin
            // Only the original byte decides whether it is a mosaic position.
            if (!(b >= ESC_CTL_FIRST && b <= ESC_CTL_LAST))
                ch = ch | MOSAIC_BIT;
            if (ch >= MOSAIC_MIN)
                attr.held = attr.sep ? (ch & ~MOSAIC_BIT) : ch;
        end
        pred = make_cell(ch, attr.sep, 1'b0);
        return 1'b1;
    endfunction

    function automatic logic [7:0] c1(input logic [7:0] ctl);
        return ctl + C1_OFFSET;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [7:0] code);
        int    gap;
        cell_t pred;
        gap = $urandom_range(send_max_gap, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.operation = op;
        item_ch.code      = code;
        do @(posedge clk); while (!item_ch.ready);
        if (decode_word(op, code, pred))
        begin
            expected_cells.push_back(pred);
            cells_predicted++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_micro(input logic value);
        drain();
        // Words that produce no cell may still be in flight.
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        micro_model = value;
    endtask

    // Result side: a random wait after each taken word, or a long hold-off
    // when a test asks for one.
    initial
    begin : result_ready_driver
        logic took;
        int   wait_left;
        wait_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            took = cell_ch.valid && cell_ch.ready;
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                cell_ch.ready = 1'b0;
            end
            else
            begin
                if (took)
                    wait_left = $urandom_range(recv_max_gap, 0);
                if (wait_left > 0)
                begin
                    wait_left--;
                    cell_ch.ready = 1'b0;
                end
                else
                begin
                    cell_ch.ready = 1'b1;
                end
            end
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : cell_checker
        cell_t want;
        if (rst_n && cell_ch.valid && cell_ch.ready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("cell with glyph 0x%0h arrived with none expected", cell_ch.glyph);
                fail_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                compare_field("glyph", want.glyph, cell_ch.glyph);
                compare_field("fore_colour", want.fore_colour, cell_ch.fore_colour);
                compare_field("back_colour", want.back_colour, cell_ch.back_colour);
                compare_field("flashing", want.flashing, cell_ch.flashing);
                compare_field("concealed", want.concealed, cell_ch.concealed);
                compare_field("double_height", want.double_height, cell_ch.double_height);
                compare_field("separated", want.separated, cell_ch.separated);
                compare_field("control_cell", want.control_cell, cell_ch.control_cell);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_plain();
        set_micro(1'b0);
        send_word(OP_ROW_START, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h41);
        send_word(OP_BYTE, CODE_DEL);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, c1(CTL_FLASH));
        send_word(OP_BYTE, c1(CTL_STEADY));
        send_word(OP_BYTE, c1(CTL_MOSAIC_FIRST + 8'd1));
        send_word(OP_BYTE, CODE_HASH);
        send_word(OP_BYTE, c1(CTL_HOLD));
        send_word(OP_BYTE, c1(CTL_SEPARATED));
        send_word(OP_BYTE, CODE_DEL);
        send_word(OP_BYTE, c1(CTL_CONCEAL));
        send_word(OP_BYTE, CODE_ESC);
        send_word(OP_BYTE, CTL_RELEASE);
        // An escape followed by a byte outside the control range is dropped.
        send_word(OP_BYTE, CODE_ESC);
        send_word(OP_BYTE, 8'h30);
        send_word(OP_BYTE, c1(CTL_NEW_BACK));
        send_word(OP_BYTE, c1(CTL_BLACK_BACK));
        send_word(OP_BYTE, c1(CTL_DOUBLE));
        send_word(OP_BYTE, c1(CTL_NORMAL));
        send_word(OP_BYTE, c1(CTL_CONTIGUOUS));
        send_word(OP_BYTE, 8'h0D);
    endtask

    task automatic test_directed_micro();
        set_micro(1'b1);
        send_word(OP_BYTE, CODE_HASH);
        send_word(OP_BYTE, CODE_UNDERLINE);
        send_word(OP_BYTE, CODE_BACKTICK);
        send_word(OP_BYTE, CODE_DEL);
        send_word(OP_BYTE, CODE_ESC);
        send_word(OP_BYTE, 8'h41);
    endtask

    task automatic send_random_row();
        int         len;
        int         pick;
        logic [7:0] b;
        send_word(OP_ROW_START, 8'($urandom()));
        len = $urandom_range(40, 1);
        repeat (len)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 24)
            begin
                // Lean toward the controls that drive mosaics and hold.
                case ($urandom_range(5, 0))
                    0:       b = CTL_HOLD;
                    1:       b = CTL_SEPARATED;
                    2:       b = CTL_CONTIGUOUS;
                    3:       b = CTL_MOSAIC_FIRST + 8'($urandom_range(6, 0));
                    default: b = ESC_CTL_FIRST + 8'($urandom_range(31, 0));
                endcase
                if (!micro_model && $urandom_range(1, 0) == 1)
                begin
                    send_word(OP_BYTE, CODE_ESC);
                    send_word(OP_BYTE, b);
                end
                else
                begin
                    send_word(OP_BYTE, c1(b));
                end
            end
            else if (pick < 31)
                send_word(OP_BYTE, 8'($urandom_range(31, 0)));
            else if (pick < 35)
            begin
                send_word(OP_BYTE, CODE_ESC);
                send_word(OP_BYTE, 8'($urandom()));
            end
            else if (pick < 44)
                send_word(OP_BYTE, 8'($urandom_range(255, 160)));
            else if (pick < 52)
            begin
                case ($urandom_range(3, 0))
                    0:       send_word(OP_BYTE, CODE_HASH);
                    1:       send_word(OP_BYTE, CODE_UNDERLINE);
                    2:       send_word(OP_BYTE, CODE_BACKTICK);
                    default: send_word(OP_BYTE, CODE_DEL);
                endcase
            end
            else if (pick < 54)
                send_word(OP_ROW_START, 8'($urandom()));
            else
                send_word(OP_BYTE, 8'($urandom_range(127, 32)));
        end
    endtask

    task automatic test_random_rows(input int cells, input logic micro,
                                    input int smax, input int rmax);
        int target;
        set_micro(micro);
        send_max_gap = smax;
        recv_max_gap = rmax;
        target = cells_predicted + cells;
        while (cells_predicted < target)
            send_random_row();
    endtask

    // The result side holds off while words keep coming, so the block fills
    // and has to stall its input.
    task automatic test_output_stall();
        send_max_gap = 0;
        recv_max_gap = 2;
        hold_cycles  = 80;
        send_word(OP_BYTE, c1(CTL_MOSAIC_FIRST + 8'd3));
        repeat (40)
            send_word(OP_BYTE, 8'($urandom_range(127, 32)));
    endtask

    task automatic test_sender_pause();
        send_max_gap = 8;
        recv_max_gap = 8;
        repeat (3)
        begin
            send_random_row();
            drain();
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = OP_BYTE;
        item_ch.code      = 8'h00;
        cell_ch.ready     = 1'b0;
        fail_count        = 0;
        cells_predicted   = 0;
        send_max_gap      = 8;
        recv_max_gap      = 8;
        hold_cycles       = 0;
        micro_model       = 1'b0;
        clear_row();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_plain();
        test_directed_micro();
        test_random_rows(180, 1'b0, 8, 8);
        test_random_rows(140, 1'b1, 8, 8);
        test_random_rows(80, 1'b0, 0, 0);
        test_random_rows(80, 1'b1, 3, 0);
        test_output_stall();
        test_sender_pause();
        test_random_rows(30, 1'b0, 2, 6);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* serial_attribute_cell_decoder.f */
rtl/sacd_pkg.sv
rtl/sacd_if.sv
rtl/sacd_cell.sv
rtl/serial_attribute_cell_decoder.sv
tb/tb_top.sv
